>>> rtl/swdh_pkg.sv
// Shared types and constants for the SWD host transfer engine.
// No dependencies; the step logic, result register and top level take names from here by scope.
`timescale 1ns / 1ps

package swdh_pkg;

  localparam logic [7:0]  MaxAttemptsReset = 8'd15;
  localparam logic [15:0] InitSeqWord      = 16'hE79E;
  localparam logic [6:0]  LineResetBits    = 7'd64;
  localparam logic [6:0]  InitSeqBits      = 7'd16;
  localparam logic [6:0]  RequestBits      = 7'd8;
  localparam logic [6:0]  AckBits          = 7'd3;
  localparam logic [6:0]  WordBits         = 7'd32;
  localparam logic [2:0]  AckOk            = 3'd1;
  localparam logic [3:0]  IdcodeRequest    = 4'h2;

  typedef enum logic [12:0] {
    PH_IDLE     = 13'b0000000000001,
    PH_INIT1    = 13'b0000000000010,
    PH_INITSEQ  = 13'b0000000000100,
    PH_INIT2    = 13'b0000000001000,
    PH_INIT0    = 13'b0000000010000,
    PH_REQ      = 13'b0000000100000,
    PH_ACK      = 13'b0000001000000,
    PH_RDATA    = 13'b0000010000000,
    PH_RPAR     = 13'b0000100000000,
    PH_WDATA    = 13'b0001000000000,
    PH_WPAR     = 13'b0010000000000,
    PH_IDLEBIT  = 13'b0100000000000,
    PH_FLUSH    = 13'b1000000000000
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [6:0]  bit_counter;
    logic [31:0] shift_word;
    logic        host_drives;
    logic [7:0]  attempts_left;
    logic        parity_acc;
    logic [3:0]  latched_request;
    logic [31:0] latched_write_word;
    logic [2:0]  ack_reg;
  } swdh_state_t;

  localparam swdh_state_t StateReset = '{
    phase:              PH_IDLE,
    bit_counter:        7'd0,
    shift_word:         32'd0,
    host_drives:        1'b0,
    attempts_left:      8'd0,
    parity_acc:         1'b0,
    latched_request:    4'd0,
    latched_write_word: 32'd0,
    ack_reg:            3'd0
  };

  typedef struct packed {
    logic        start_req;
    logic        mode;
    logic        ap_not_dp;
    logic        read_not_write;
    logic [1:0]  reg_addr;
    logic [31:0] write_data;
    logic        swdio_in;
  } swdh_item_t;

  typedef struct packed {
    logic        clock_pulse;
    logic        swdio_out;
    logic        swdio_oe;
    logic        busy_res;
    logic        done_res;
    logic        ok;
    logic [2:0]  ack;
    logic [31:0] read_data;
  } swdh_result_t;

endpackage

>>> rtl/swdh_if.sv
// Valid/ready channel interfaces: input items, result items, config writes.
// Depends on nothing; used by the top level and the result register.
`timescale 1ns / 1ps

interface swdh_in_if;
  logic        valid;
  logic        ready;
  logic        start_req;
  logic        mode;
  logic        ap_not_dp;
  logic        read_not_write;
  logic [1:0]  reg_addr;
  logic [31:0] write_data;
  logic        swdio_in;

  modport source (output valid, start_req, mode, ap_not_dp, read_not_write, reg_addr,
                  write_data, swdio_in, input ready);
  modport sink   (input valid, start_req, mode, ap_not_dp, read_not_write, reg_addr,
                  write_data, swdio_in, output ready);
endinterface

interface swdh_out_if;
  logic        valid;
  logic        ready;
  logic        clock_pulse;
  logic        swdio_out;
  logic        swdio_oe;
  logic        busy_res;
  logic        done_res;
  logic        ok;
  logic [2:0]  ack;
  logic [31:0] read_data;

  modport source (output valid, clock_pulse, swdio_out, swdio_oe, busy_res, done_res, ok,
                  ack, read_data, input ready);
  modport sink   (input valid, clock_pulse, swdio_out, swdio_oe, busy_res, done_res, ok,
                  ack, read_data, output ready);
endinterface

interface swdh_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] max_attempts;

  modport source (output valid, max_attempts, input ready);
  modport sink   (input valid, max_attempts, output ready);
endinterface

>>> rtl/swd_host_transfer_engine.sv
// SWD host transfer engine top level: state and config registers, step logic,
// result register. Depends on swdh_pkg, swdh_if, swdh_step and swdh_out_reg.
//
// Each input item on in_i is one bit period on the wire: the sampled data
// line plus an optional command (transfer or line-reset-and-ID read). Each
// accepted item yields exactly one result item on out_o: clock pulse,
// driven level and enable, busy/done/ok, last acknowledge and read word.
// The result is registered and appears in the cycle after the item is taken;
// the block takes one item per cycle, limited by the single result register,
// which accepts a new item whenever it is empty or being drained that cycle.
// When out_o stalls, in_i.ready drops and the command state holds.
// cfg_i writes max_attempts (attempts per transfer, 0 acts as 1) and is
// always ready; write it only while no command is running.
// Reset clears the command state to idle with the line released, the
// acknowledge to zero, max_attempts to 15, and empties the result register.
`timescale 1ns / 1ps

module swd_host_transfer_engine (
  input logic         clk_i,
  input logic         rst_ni,
  swdh_in_if.sink     in_i,
  swdh_out_if.source  out_o,
  swdh_cfg_if.sink    cfg_i
);

  swdh_pkg::swdh_state_t  state_q;
  swdh_pkg::swdh_state_t  state_d;
  swdh_pkg::swdh_item_t   item;
  swdh_pkg::swdh_result_t result;
  logic [7:0]             max_attempts_q;
  logic                   free;
  logic                   accept;

  assign item = '{
    start_req:      in_i.start_req,
    mode:           in_i.mode,
    ap_not_dp:      in_i.ap_not_dp,
    read_not_write: in_i.read_not_write,
    reg_addr:       in_i.reg_addr,
    write_data:     in_i.write_data,
    swdio_in:       in_i.swdio_in
  };

  assign in_i.ready  = free;
  assign accept      = in_i.valid && free;
  assign cfg_i.ready = 1'b1;

  swdh_step u_step (
    .state_i        (state_q),
    .item_i         (item),
    .max_attempts_i (max_attempts_q),
    .state_o        (state_d),
    .result_o       (result)
  );

  swdh_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .result_i (result),
    .free_o   (free),
    .out_o    (out_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swdh_pkg::StateReset;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_attempts_q <= swdh_pkg::MaxAttemptsReset;
    end else if (cfg_i.valid) begin
      max_attempts_q <= cfg_i.max_attempts;
    end
  end

endmodule

>>> rtl/swdh_step.sv
// Next-state and result logic for one bit period of the SWD host.
// Depends on swdh_pkg.
`timescale 1ns / 1ps

module swdh_step (
  input  swdh_pkg::swdh_state_t  state_i,
  input  swdh_pkg::swdh_item_t   item_i,
  input  logic [7:0]             max_attempts_i,
  output swdh_pkg::swdh_state_t  state_o,
  output swdh_pkg::swdh_result_t result_o
);

  swdh_pkg::swdh_state_t  st;
  swdh_pkg::swdh_result_t res;
  logic [7:0]             first_attempts;
  logic [7:0]             request_byte;
  logic [6:0]             bc_inc;
  logic [2:0]             ack_new;
  logic                   wants_drive;

  assign first_attempts = (max_attempts_i == 8'd0) ? 8'd1 : max_attempts_i;

  always_comb begin
    st             = state_i;
    res            = '0;
    res.swdio_oe   = state_i.host_drives;
    request_byte   = 8'd0;
    bc_inc         = 7'd0;
    ack_new        = 3'd0;
    wants_drive    = 1'b0;

    if ((state_i.phase == swdh_pkg::PH_IDLE) && item_i.start_req) begin
      st.bit_counter = 7'd0;
      if (item_i.mode) begin
        st.latched_request    = swdh_pkg::IdcodeRequest;
        st.latched_write_word = 32'd0;
        st.phase              = swdh_pkg::PH_INIT1;
      end else begin
        st.latched_request    = {item_i.reg_addr, item_i.read_not_write, item_i.ap_not_dp};
        st.latched_write_word = item_i.write_data;
        st.attempts_left      = first_attempts;
        st.phase              = swdh_pkg::PH_REQ;
      end
    end

    request_byte = {1'b1, 1'b0, ^st.latched_request, st.latched_request, 1'b1};
    bc_inc       = st.bit_counter + 7'd1;
    ack_new      = ((st.bit_counter == 7'd0) ? 3'd0 : st.ack_reg)
                   | (3'(item_i.swdio_in) << st.bit_counter[1:0]);

    if (st.phase != swdh_pkg::PH_IDLE) begin
      res.clock_pulse = 1'b1;
      res.busy_res    = 1'b1;
      wants_drive     = !((st.phase == swdh_pkg::PH_ACK) || (st.phase == swdh_pkg::PH_RDATA)
                          || (st.phase == swdh_pkg::PH_RPAR));
      if (st.host_drives != wants_drive) begin
        res.swdio_oe   = 1'b0;
        st.host_drives = wants_drive;
      end else begin
        res.swdio_oe = wants_drive;
        case (st.phase)
          swdh_pkg::PH_INIT1, swdh_pkg::PH_INIT2: begin
            res.swdio_out  = 1'b1;
            st.bit_counter = bc_inc;
            if (bc_inc >= swdh_pkg::LineResetBits) begin
              st.bit_counter = 7'd0;
              st.phase = (st.phase == swdh_pkg::PH_INIT1) ? swdh_pkg::PH_INITSEQ
                                                           : swdh_pkg::PH_INIT0;
            end
          end
          swdh_pkg::PH_INITSEQ: begin
            res.swdio_out  = swdh_pkg::InitSeqWord[st.bit_counter[3:0]];
            st.bit_counter = bc_inc;
            if (bc_inc >= swdh_pkg::InitSeqBits) begin
              st.bit_counter = 7'd0;
              st.phase       = swdh_pkg::PH_INIT2;
            end
          end
          swdh_pkg::PH_INIT0: begin
            st.bit_counter = bc_inc;
            if (bc_inc >= swdh_pkg::LineResetBits) begin
              st.attempts_left = first_attempts;
              st.bit_counter   = 7'd0;
              st.phase         = swdh_pkg::PH_REQ;
            end
          end
          swdh_pkg::PH_REQ: begin
            res.swdio_out  = request_byte[st.bit_counter[2:0]];
            st.bit_counter = bc_inc;
            if (bc_inc >= swdh_pkg::RequestBits) begin
              st.bit_counter = 7'd0;
              st.phase       = swdh_pkg::PH_ACK;
            end
          end
          swdh_pkg::PH_ACK: begin
            st.ack_reg     = ack_new;
            st.bit_counter = bc_inc;
            if (bc_inc >= swdh_pkg::AckBits) begin
              st.bit_counter = 7'd0;
              if (ack_new == swdh_pkg::AckOk) begin
                if (st.latched_request[1]) begin
                  st.shift_word = 32'd0;
                  st.parity_acc = 1'b0;
                  st.phase      = swdh_pkg::PH_RDATA;
                end else begin
                  st.phase = swdh_pkg::PH_WDATA;
                end
              end else begin
                st.phase = swdh_pkg::PH_FLUSH;
              end
            end
          end
          swdh_pkg::PH_RDATA: begin
            st.shift_word  = st.shift_word | (32'(item_i.swdio_in) << st.bit_counter[4:0]);
            st.parity_acc  = st.parity_acc ^ item_i.swdio_in;
            st.bit_counter = bc_inc;
            if (bc_inc >= swdh_pkg::WordBits) begin
              st.bit_counter = 7'd0;
              st.phase       = swdh_pkg::PH_RPAR;
            end
          end
          swdh_pkg::PH_RPAR: begin
            st.phase = (item_i.swdio_in == st.parity_acc) ? swdh_pkg::PH_IDLEBIT
                                                           : swdh_pkg::PH_FLUSH;
            st.bit_counter = 7'd0;
          end
          swdh_pkg::PH_WDATA: begin
            res.swdio_out  = st.latched_write_word[st.bit_counter[4:0]];
            st.bit_counter = bc_inc;
            if (bc_inc >= swdh_pkg::WordBits) begin
              st.bit_counter = 7'd0;
              st.phase       = swdh_pkg::PH_WPAR;
            end
          end
          swdh_pkg::PH_WPAR: begin
            res.swdio_out = ^st.latched_write_word;
            st.phase      = swdh_pkg::PH_IDLEBIT;
          end
          swdh_pkg::PH_IDLEBIT: begin
            res.done_res     = 1'b1;
            res.ok           = 1'b1;
            res.read_data    = st.latched_request[1] ? st.shift_word : 32'd0;
            st.phase         = swdh_pkg::PH_IDLE;
            st.attempts_left = 8'd0;
          end
          swdh_pkg::PH_FLUSH: begin
            st.bit_counter = bc_inc;
            if (bc_inc >= swdh_pkg::WordBits) begin
              st.bit_counter = 7'd0;
              if (st.attempts_left > 8'd1) begin
                st.attempts_left = st.attempts_left - 8'd1;
                st.phase         = swdh_pkg::PH_REQ;
              end else begin
                st.attempts_left = 8'd0;
                res.done_res     = 1'b1;
                st.phase         = swdh_pkg::PH_IDLE;
              end
            end
          end
          default: begin
            st.phase       = swdh_pkg::PH_IDLE;
            st.bit_counter = 7'd0;
          end
        endcase
      end
    end

    res.ack = st.ack_reg;
  end

  assign state_o  = st;
  assign result_o = res;

endmodule

>>> rtl/swdh_out_reg.sv
// Result register driving the output channel; frees itself as items leave.
// Depends on swdh_pkg and swdh_out_if.
`timescale 1ns / 1ps

module swdh_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  swdh_pkg::swdh_result_t result_i,
  output logic                   free_o,
  swdh_out_if.source             out_o
);

  logic                   valid_q;
  logic                   valid_d;
  swdh_pkg::swdh_result_t result_q;

  assign free_o  = !valid_q || out_o.ready;
  assign valid_d = load_i || (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.clock_pulse = result_q.clock_pulse;
  assign out_o.swdio_out   = result_q.swdio_out;
  assign out_o.swdio_oe    = result_q.swdio_oe;
  assign out_o.busy_res    = result_q.busy_res;
  assign out_o.done_res    = result_q.done_res;
  assign out_o.ok          = result_q.ok;
  assign out_o.ack         = result_q.ack;
  assign out_o.read_data   = result_q.read_data;

endmodule

>>> rtl/swdh_checker.sv
// Port-level checks on the SWD host result channel, bound to the top level.
// Depends on swd_host_transfer_engine and its interface ports.
`timescale 1ns / 1ps

module swdh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        clock_pulse_i,
  input logic        swdio_out_i,
  input logic        swdio_oe_i,
  input logic        busy_res_i,
  input logic        done_res_i,
  input logic        ok_i,
  input logic [31:0] read_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(read_data_i) && $stable(done_res_i))
    else $error("result item changed while stalled");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && done_res_i |-> busy_res_i && clock_pulse_i)
    else $error("done without an active bit period");

  a_ok_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ok_i |-> done_res_i)
    else $error("ok outside a finishing bit period");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !clock_pulse_i |-> !busy_res_i && !done_res_i && !swdio_out_i
                                      && (read_data_i == 32'd0))
    else $error("idle bit period shows activity");

  a_released_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !swdio_oe_i |-> !swdio_out_i)
    else $error("driven level high while line released");

endmodule

bind swd_host_transfer_engine swdh_checker u_swdh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .clock_pulse_i (out_o.clock_pulse),
  .swdio_out_i   (out_o.swdio_out),
  .swdio_oe_i    (out_o.swdio_oe),
  .busy_res_i    (out_o.busy_res),
  .done_res_i    (out_o.done_res),
  .ok_i          (out_o.ok),
  .read_data_i   (out_o.read_data)
);
